// ===== design/gsfc_pkg.sv =====
`default_nettype none
package gsfc_pkg;

	localparam int unsigned BODY_CAPACITY = 256;
	localparam int unsigned BODY_W = $clog2(BODY_CAPACITY);
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BODY  = 2'd1,
		PH_CHECK = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_HEADING  = 3'd1,
		ST_AGRICA   = 3'd2,
		ST_BAD_CRC  = 3'd3,
		ST_BAD_FORM = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	// number parser state
	typedef struct packed {
		logic [1:0] frac_cnt;
		logic       stop;
		logic       dot;
		logic       neg;
		logic       started;
	} num_flags_t;

	function automatic logic [7:0] heading_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = 8'h55;
			4'd1: c = 8'h4E;
			4'd2: c = 8'h49;
			4'd3: c = 8'h48;
			4'd4: c = 8'h45;
			4'd5: c = 8'h41;
			4'd6: c = 8'h44;
			4'd7: c = 8'h49;
			4'd8: c = 8'h4E;
			4'd9: c = 8'h47;
			4'd10: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] agrica_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h41;
			3'd1: c = 8'h47;
			3'd2: c = 8'h52;
			3'd3: c = 8'h49;
			3'd4: c = 8'h43;
			3'd5: c = 8'h41;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] c);
		logic [31:0] r;
		r = crc ^ {24'd0, c};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/gsfc_num.sv =====
`default_nettype none
// one character step of the decimal-to-thousandths parser
module gsfc_num (
	input  wire logic [7:0]              c,
	input  wire logic [31:0]             acc,
	input  wire gsfc_pkg::num_flags_t    fl,
	output logic [31:0]                  acc_nx,
	output gsfc_pkg::num_flags_t         fl_nx
);
	logic        is_digit;
	logic [3:0]  d;
	logic [35:0] m;
	logic [35:0] add;
	logic        blank;

	always_comb begin
		is_digit = (c >= 8'h30) && (c <= 8'h39);
		d = c[3:0];
		blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
		acc_nx = acc;
		fl_nx = fl;
		m = 36'd0;
		add = 36'd0;
		if (!fl.stop) begin
			if (!fl.started && blank) begin
				fl_nx = fl;
			end else if (!fl.started && (c == 8'h2B || c == 8'h2D)) begin
				fl_nx.started = 1'b1;
				fl_nx.neg = (c == 8'h2D);
			end else begin
				fl_nx.started = 1'b1;
				if (is_digit) begin
					if (!fl.dot) begin
						// acc*10 + d*1000
						m = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
							+ ({32'd0, d} << 10) - ({32'd0, d} << 4) - ({32'd0, d} << 3);
					end else begin
						unique case (fl.frac_cnt)
							2'd0: add = ({32'd0, d} << 6) + ({32'd0, d} << 5)
								+ ({32'd0, d} << 2);
							2'd1: add = ({32'd0, d} << 3) + ({32'd0, d} << 1);
							2'd2: add = {32'd0, d};
							default: add = 36'd0;
						endcase
						m = {4'd0, acc} + add;
						if (fl.frac_cnt != 2'd3) fl_nx.frac_cnt = fl.frac_cnt + 2'd1;
					end
					acc_nx = (m > {4'd0, gsfc_pkg::MAG_LIMIT}) ? gsfc_pkg::MAG_LIMIT : m[31:0];
				end else if (c == 8'h2E && !fl.dot) begin
					fl_nx.dot = 1'b1;
				end else begin
					fl_nx.stop = 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/gnss_sentence_framer_crc_check.sv =====
// gnss sentence framer with crc-32 check and heading extraction
// input channel: one ascii character per beat on ch (in_valid / in_ready)
// output channel: one result beat per input beat (out_valid / out_ready):
//   status, baseline_mm, heading_mdeg, heading_sd_mdeg
// a sentence runs from '#' to '*' and is followed by 8 check characters;
// the verdict appears on the beat of the 8th check character, all other
// beats carry status none and zero values
// the result beat is registered and appears in the cycle after acceptance
// throughput: one character per cycle while the output is not stalled; crc
// update, prefix match and digit accumulation all finish in the single pass
// between input and result regs; when out_ready is low a full result
// register holds and in_ready follows out_ready, so the input side keeps
// taking beats only while the result register is empty or being drained
// reset (arst_n low) clears the parser to idle, waiting for '#', and empties
// the result register
`default_nettype none
module gnss_sentence_framer_crc_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic signed [31:0] baseline_mm,
	output logic signed [31:0] heading_mdeg,
	output logic signed [31:0] heading_sd_mdeg
);
	localparam int unsigned BW = gsfc_pkg::BODY_W + 1;

	gsfc_pkg::phase_t     phase_q, phase_d;
	logic [BW-1:0]        body_q, body_d;
	logic [31:0]          crc_q, crc_d;
	logic [3:0]           cdc_q, cdc_d;
	logic [31:0]          cval_q, cval_d;
	logic                 copen_q, copen_d;
	logic [1:0]           pfx_q, pfx_d;
	logic                 semi_q, semi_d;
	logic [2:0]           tok_q, tok_d;
	logic                 intok_q, intok_d;
	logic [31:0]          acc_q, acc_d;
	gsfc_pkg::num_flags_t nfl_q, nfl_d;
	logic [31:0]          cap_q [3];
	logic [31:0]          cap_d [3];

	logic                 ovalid_q;
	logic [2:0]           st_q;
	logic [31:0]          v0_q, v1_q, v2_q;
	logic [2:0]           st_d;
	logic                 give;

	logic [31:0]          num_acc_in, num_acc_out;
	gsfc_pkg::num_flags_t num_fl_in, num_fl_out;
	logic                 fire;

	assign in_ready = !ovalid_q || out_ready;
	assign fire = in_valid && in_ready;

	gsfc_num u_num (
		.c(ch), .acc(num_acc_in), .fl(num_fl_in),
		.acc_nx(num_acc_out), .fl_nx(num_fl_out)
	);

	function automatic logic slot_hit(input logic [2:0] t);
		return (t == 3'd2) || (t == 3'd3) || (t == 3'd6);
	endfunction

	function automatic logic [1:0] slot_idx(input logic [2:0] t);
		return (t == 3'd2) ? 2'd0 : ((t == 3'd3) ? 2'd1 : 2'd2);
	endfunction

	function automatic logic [31:0] finish_val(input logic [31:0] a,
			input gsfc_pkg::num_flags_t f);
		if (f.neg) return 32'd0 - a;
		return (a > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : a;
	endfunction

	always_comb begin
		logic [4:0] d;
		logic       hexd;
		logic [3:0] cnt1;
		logic [2:0] ntok;
		phase_d = phase_q;
		body_d = body_q;
		crc_d = crc_q;
		cdc_d = cdc_q;
		cval_d = cval_q;
		copen_d = copen_q;
		pfx_d = pfx_q;
		semi_d = semi_q;
		tok_d = tok_q;
		intok_d = intok_q;
		acc_d = acc_q;
		nfl_d = nfl_q;
		cap_d = cap_q;
		st_d = gsfc_pkg::ST_NONE;
		give = 1'b0;
		num_acc_in = acc_q;
		num_fl_in = nfl_q;
		d = 5'd16;
		hexd = 1'b0;
		cnt1 = cdc_q + 4'd1;
		ntok = tok_q;
		unique case (phase_q)
			gsfc_pkg::PH_BODY: begin
				if (ch == 8'h2A) begin
					if (intok_q) begin
						if (slot_hit(tok_q)) cap_d[slot_idx(tok_q)] = finish_val(acc_q, nfl_q);
						intok_d = 1'b0;
					end
					phase_d = gsfc_pkg::PH_CHECK;
					cdc_d = 4'd0;
					cval_d = 32'd0;
					copen_d = 1'b1;
				end else if (body_q >= BW'(gsfc_pkg::BODY_CAPACITY - 1)) begin
					phase_d = gsfc_pkg::PH_IDLE;
					body_d = '0;
					cdc_d = 4'd0;
				end else begin
					crc_d = gsfc_pkg::crc_byte(crc_q, ch);
					if (body_q < BW'(11) && ch != gsfc_pkg::heading_char(body_q[3:0]))
						pfx_d[0] = 1'b0;
					if (body_q < BW'(6) && ch != gsfc_pkg::agrica_char(body_q[2:0]))
						pfx_d[1] = 1'b0;
					if (!semi_q) begin
						if (ch == 8'h3B) begin
							semi_d = 1'b1;
							tok_d = 3'd0;
							intok_d = 1'b1;
						end
					end else if (ch == 8'h2C) begin
						if (intok_q) begin
							if (slot_hit(tok_q))
								cap_d[slot_idx(tok_q)] = finish_val(acc_q, nfl_q);
							intok_d = 1'b0;
						end
					end else begin
						if (!intok_q) begin
							intok_d = 1'b1;
							if (tok_q < 3'd7) ntok = tok_q + 3'd1;
							tok_d = ntok;
							if (slot_hit(ntok)) begin
								num_acc_in = 32'd0;
								num_fl_in = '0;
							end
						end
						if (slot_hit(ntok)) begin
							acc_d = num_acc_out;
							nfl_d = num_fl_out;
						end
					end
					body_d = body_q + BW'(1);
				end
			end
			gsfc_pkg::PH_CHECK: begin
				if (ch >= 8'h30 && ch <= 8'h39) d = {1'b0, ch[3:0]};
				else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
					d = {1'b0, ch[3:0] + 4'd9};
				hexd = !d[4];
				if (copen_q && hexd) cval_d = {cval_q[27:0], d[3:0]};
				else copen_d = 1'b0;
				cdc_d = cnt1;
				if (cnt1 >= 4'd8) begin
					if (crc_q != cval_d) st_d = gsfc_pkg::ST_BAD_CRC;
					else if (pfx_q[0] && body_q >= BW'(11)) begin
						if (semi_q && tok_q >= 3'd6) begin
							st_d = gsfc_pkg::ST_HEADING;
							give = 1'b1;
						end else st_d = gsfc_pkg::ST_BAD_FORM;
					end else if (pfx_q[1] && body_q >= BW'(6)) st_d = gsfc_pkg::ST_AGRICA;
					else st_d = gsfc_pkg::ST_UNKNOWN;
					phase_d = gsfc_pkg::PH_IDLE;
					body_d = '0;
					cdc_d = 4'd0;
				end
			end
			default: begin
				phase_d = gsfc_pkg::PH_IDLE;
				if (ch == 8'h23) begin
					phase_d = gsfc_pkg::PH_BODY;
					body_d = '0;
					crc_d = 32'd0;
					pfx_d = 2'b11;
					semi_d = 1'b0;
					tok_d = 3'd0;
					intok_d = 1'b0;
					acc_d = 32'd0;
					nfl_d = '0;
					cap_d[0] = 32'd0;
					cap_d[1] = 32'd0;
					cap_d[2] = 32'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gsfc_pkg::PH_IDLE;
			body_q <= '0;
			crc_q <= 32'd0;
			cdc_q <= 4'd0;
			cval_q <= 32'd0;
			copen_q <= 1'b1;
			pfx_q <= 2'b11;
			semi_q <= 1'b0;
			tok_q <= 3'd0;
			intok_q <= 1'b0;
			acc_q <= 32'd0;
			nfl_q <= '0;
			cap_q[0] <= 32'd0;
			cap_q[1] <= 32'd0;
			cap_q[2] <= 32'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				body_q <= body_d;
				crc_q <= crc_d;
				cdc_q <= cdc_d;
				cval_q <= cval_d;
				copen_q <= copen_d;
				pfx_q <= pfx_d;
				semi_q <= semi_d;
				tok_q <= tok_d;
				intok_q <= intok_d;
				acc_q <= acc_d;
				nfl_q <= nfl_d;
				cap_q <= cap_d;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (fire) begin
			st_q <= st_d;
			v0_q <= give ? cap_q[0] : 32'd0;
			v1_q <= give ? cap_q[1] : 32'd0;
			v2_q <= give ? cap_q[2] : 32'd0;
		end
	end

	assign out_valid = ovalid_q;
	assign status = st_q;
	assign baseline_mm = v0_q;
	assign heading_mdeg = v1_q;
	assign heading_sd_mdeg = v2_q;
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	typedef struct packed {
		gsfc_pkg::status_t st;
		logic [31:0] base;
		logic [31:0] hdg;
		logic [31:0] hsd;
	} verdict_t;

	typedef struct {
		logic [7:0] c;
		logic       typed;
		verdict_t   want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] ch = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic signed [31:0] baseline_mm, heading_mdeg, heading_sd_mdeg;

	gnss_sentence_framer_crc_check i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .ch(ch),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .baseline_mm(baseline_mm),
		.heading_mdeg(heading_mdeg), .heading_sd_mdeg(heading_sd_mdeg)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// framer state mirror
	gsfc_pkg::phase_t f_phase = gsfc_pkg::PH_IDLE;
	int         f_count = 0;
	logic [31:0] f_crc = '0;
	int         f_ndig = 0;
	logic [31:0] f_chk = '0;
	logic       f_hex_open = 1'b1;
	logic       f_hd_ok = 1'b1, f_ag_ok = 1'b1;
	logic       f_semi = 1'b0;
	int         f_tok = 0;
	logic       f_in_tok = 1'b0;
	logic [31:0] f_mag = '0;
	gsfc_pkg::num_flags_t f_nf = '0;
	logic [31:0] f_cap [3];

	verdict_t verdicts_due [$];
	int errors = 0;
	int sender_idle = 0, receiver_idle = 0;
	int hold_off = 0;
	int sent = 0;
	string hdg_pfx = "UNIHEADINGA";
	string agr_pfx = "AGRICA";

	function automatic int slot(int t);
		return t == 2 ? 0 : t == 3 ? 1 : t == 6 ? 2 : -1;
	endfunction

	function automatic logic [31:0] crc_step(logic [31:0] r, logic [7:0] c);
		r ^= {24'd0, c};
		repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
		return r;
	endfunction

	task automatic number_char(logic [7:0] c);
		logic [63:0] m;
		m = f_mag;
		if (f_nf.stop) return;
		if (!f_nf.started) begin
			if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return;
			f_nf.started = 1'b1;
			if (c == "+" || c == "-") begin
				if (c == "-") f_nf.neg = 1'b1;
				return;
			end
		end
		if (c >= "0" && c <= "9") begin
			if (!f_nf.dot) m = m * 10 + (c - "0") * 1000;
			else if (f_nf.frac_cnt < 3) begin
				m += (c - "0") * (f_nf.frac_cnt == 0 ? 100 : f_nf.frac_cnt == 1 ? 10 : 1);
				f_nf.frac_cnt++;
			end
			if (m > 64'h8000_0000) m = 64'h8000_0000;
			f_mag = m[31:0];
		end else if (c == "." && !f_nf.dot) f_nf.dot = 1'b1;
		else f_nf.stop = 1'b1;
	endtask

	task automatic close_token();
		int s;
		s = slot(f_tok);
		if (s < 0) return;
		if (f_nf.neg) f_cap[s] = -f_mag;
		else f_cap[s] = f_mag > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : f_mag;
	endtask

	task automatic body_byte(logic [7:0] c);
		f_crc = crc_step(f_crc, c);
		if (f_count < 11 && c != hdg_pfx[f_count]) f_hd_ok = 1'b0;
		if (f_count < 6 && c != agr_pfx[f_count]) f_ag_ok = 1'b0;
		if (!f_semi) begin
			if (c == ";") begin
				f_semi = 1'b1;
				f_tok = 0;
				f_in_tok = 1'b1;
			end
		end else if (c == ",") begin
			if (f_in_tok) begin
				close_token();
				f_in_tok = 1'b0;
			end
		end else begin
			if (!f_in_tok) begin
				f_in_tok = 1'b1;
				if (f_tok < 7) f_tok++;
				if (slot(f_tok) >= 0) begin
					f_mag = '0;
					f_nf = '0;
				end
			end
			if (slot(f_tok) >= 0) number_char(c);
		end
		f_count++;
	endtask

	function automatic int hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	task automatic frame_char(input logic [7:0] c, output verdict_t v);
		int d;
		v = '{gsfc_pkg::ST_NONE, 32'd0, 32'd0, 32'd0};
		case (f_phase)
			gsfc_pkg::PH_BODY: begin
				if (c == "*") begin
					if (f_in_tok) begin
						close_token();
						f_in_tok = 1'b0;
					end
					f_phase = gsfc_pkg::PH_CHECK;
					f_ndig = 0;
					f_chk = '0;
					f_hex_open = 1'b1;
				end else if (f_count >= gsfc_pkg::BODY_CAPACITY - 1) begin
					f_phase = gsfc_pkg::PH_IDLE;
					f_count = 0;
					f_ndig = 0;
				end else body_byte(c);
			end
			gsfc_pkg::PH_CHECK: begin
				d = hex_val(c);
				if (f_hex_open && d < 16) f_chk = (f_chk << 4) | d;
				else f_hex_open = 1'b0;
				f_ndig++;
				if (f_ndig >= 8) begin
					if (f_crc != f_chk) v.st = gsfc_pkg::ST_BAD_CRC;
					else if (f_hd_ok && f_count >= 11) begin
						if (f_semi && f_tok >= 6)
							v = '{gsfc_pkg::ST_HEADING, f_cap[0], f_cap[1], f_cap[2]};
						else v.st = gsfc_pkg::ST_BAD_FORM;
					end else if (f_ag_ok && f_count >= 6) v.st = gsfc_pkg::ST_AGRICA;
					else v.st = gsfc_pkg::ST_UNKNOWN;
					f_phase = gsfc_pkg::PH_IDLE;
					f_count = 0;
					f_ndig = 0;
				end
			end
			default: begin
				if (c == "#") begin
					f_phase = gsfc_pkg::PH_BODY;
					f_count = 0;
					f_crc = '0;
					f_hd_ok = 1'b1;
					f_ag_ok = 1'b1;
					f_semi = 1'b0;
					f_tok = 0;
					f_in_tok = 1'b0;
					f_mag = '0;
					f_nf = '0;
					f_cap = '{default: '0};
				end
			end
		endcase
	endtask

	task automatic report(string what, verdict_t got, verdict_t want);
		$display("mismatch %s: got %0d %0d %0d %0d want %0d %0d %0d %0d", what,
			got.st, $signed(got.base), $signed(got.hdg), $signed(got.hsd),
			want.st, $signed(want.base), $signed(want.hdg), $signed(want.hsd));
		errors++;
	endtask

	// send one character, predicting on acceptance
	task automatic send_char(logic [7:0] c, logic typed = 0,
			verdict_t want = '{gsfc_pkg::ST_NONE, 32'd0, 32'd0, 32'd0});
		verdict_t v;
		while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		do @(posedge clk); while (!in_ready);
		sent++;
		frame_char(c, v);
		if (typed && v != want) report("typed row", v, want);
		verdicts_due.push_back(v);
	endtask

	task automatic send_str(string s);
		foreach (s[i]) send_char(s[i]);
	endtask

	function automatic string hex8(logic [31:0] x);
		return $sformatf("%08x", x);
	endfunction

	function automatic logic [31:0] crc_of(string s);
		logic [31:0] r;
		r = '0;
		foreach (s[i]) r = crc_step(r, s[i]);
		return r;
	endfunction

	function automatic string rand_num();
		string s;
		s = "";
		case ($urandom_range(9))
			0: s = " -";
			1: s = "+";
			2: s = "-";
			default: ;
		endcase
		repeat ($urandom_range(1, 12)) s = {s, string'(8'("0" + $urandom_range(9)))};
		if ($urandom_range(2) != 0) begin
			s = {s, "."};
			repeat ($urandom_range(0, 5)) s = {s, string'(8'("0" + $urandom_range(9)))};
		end
		if ($urandom_range(9) == 0) s = {s, "e3x"};
		return s;
	endfunction

	function automatic string rand_body();
		string s;
		int k;
		k = $urandom_range(99);
		if (k < 55) begin
			s = "UNIHEADINGA,x,y;";
			for (int t = 0; t < $urandom_range(5, 9); t++) begin
				if ($urandom_range(7) == 0) s = {s, ","};
				s = {s, rand_num(), ","};
			end
		end else if (k < 75) s = {"AGRICA", rand_num()};
		else if (k < 85) s = "UNIHEADINGA;1,2";
		else begin
			s = "";
			repeat ($urandom_range(0, 20)) s = {s, string'(8'($urandom_range(255)))};
			foreach (s[i]) if (s[i] == "*") s[i] = "#";
		end
		return s;
	endfunction

	task automatic send_sentence(string body, bit good = 1);
		logic [31:0] c;
		c = crc_of(body);
		if (!good) c ^= 32'h1 << $urandom_range(31);
		send_str({"#", body, "*", hex8(c)});
	endtask

	// receiver: idle draws, plus a long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else out_ready <= !(receiver_idle > 0 && $urandom_range(99) < receiver_idle);
	end

	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{gsfc_pkg::status_t'(status), baseline_mm, heading_mdeg, heading_sd_mdeg};
			if (verdicts_due.size() == 0) begin
				report("result beat with nothing expected", got, '0);
			end else begin
				want = verdicts_due.pop_front();
				if (got.st != want.st) report("status", got, want);
				else if (got.base != want.base) report("baseline_mm", got, want);
				else if (got.hdg != want.hdg) report("heading_mdeg", got, want);
				else if (got.hsd != want.hsd) report("heading_sd_mdeg", got, want);
			end
		end
	end

	initial begin
		#50ms;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		row_t rows [$];
		string s;
		int n;
		bit held;
		held = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed table: wrong check on empty body, then garbage in idle, then a good check on empty body
		s = "#*1ZZZZZZZ";
		foreach (s[i])
			rows.push_back('{s[i], 1'b1,
				'{i == 9 ? gsfc_pkg::ST_BAD_CRC : gsfc_pkg::ST_NONE, 0, 0, 0}});
		rows.push_back('{8'hFF, 1'b1, '{gsfc_pkg::ST_NONE, 0, 0, 0}});
		rows.push_back('{8'h00, 1'b1, '{gsfc_pkg::ST_NONE, 0, 0, 0}});
		s = "#*00000000";
		foreach (s[i])
			rows.push_back('{s[i], 1'b1,
				'{i == 9 ? gsfc_pkg::ST_UNKNOWN : gsfc_pkg::ST_NONE, 0, 0, 0}});
		foreach (rows[i]) send_char(rows[i].c, rows[i].typed, rows[i].want);
		// extremes of values, saturation, truncation, bad form, agrica, bad crc, upper hex
		send_sentence("UNIHEADINGA;a,b,-99999999999,12.3456,c,d, \t+0.0019zz");
		send_sentence("UNIHEADINGA;a,,b,9999999,-2147483.648,c,d,.5");
		send_sentence("UNIHEADINGA;1,2,3,4,5");
		send_sentence("UNIHEADINGAx");
		send_sentence("AGRICA");
		send_sentence("AGRIC");
		send_sentence("HEADING;1,2", 0);
		s = "#UNIHEADINGA;a,1,2,c,d,3";
		send_str({s, "*", $sformatf("%08X", crc_of(s.substr(1, s.len() - 1)))});
		s = hex8(crc_of("AGRICA"));
		send_str({"#AGRICA*", s.substr(0, 5), "x0"});
		// overflow back to idle
		send_char("#");
		repeat (gsfc_pkg::BODY_CAPACITY) send_char(8'($urandom_range(255)) | 8'h80);
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle = ph == 0 ? 6 : ph == 1 ? 61 : 0;
			receiver_idle = ph == 0 ? 61 : ph == 1 ? 6 : 0;
			n = sent;
			while (sent - n < 470) begin
				if (ph == 2 && !held && sent - n >= 100) begin
					hold_off = 300;
					held = 1;
				end
				if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)));
				else send_sentence(rand_body(), $urandom_range(7) != 0);
			end
		end
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire
